[sv/energy_meter_response_decoder_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the energy meter response decoder
// Clocked, reset-qualified property wrappers shared by the RTL modules.
// ---------------------------------------------------------------------------
`ifndef ENERGY_METER_RESPONSE_DECODER_ASSERT_SVH
`define ENERGY_METER_RESPONSE_DECODER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define EMRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define EMRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/emrd_pkg.sv]
// ---------------------------------------------------------------------------
// emrd_pkg
// Shared types, constants and the CRC-16 byte update for the decoder.
// ---------------------------------------------------------------------------
package emrd_pkg;

  localparam int unsigned FRAME_BYTES_DEF = 27;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam int unsigned PAYLOAD_FIRST   = 3;
  localparam int unsigned PAYLOAD_DEPTH   = 21;
  localparam int unsigned PAYLOAD_END     = PAYLOAD_FIRST + PAYLOAD_DEPTH;
  localparam int unsigned COUNT_W         = 5;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;
  localparam int unsigned QDEPTH          = 2;   // power of two
  localparam int unsigned QPTR_W          = $clog2(QDEPTH);
  localparam int unsigned QCNT_W          = $clog2(QDEPTH + 1);
  localparam int unsigned OUT_DATA_W      = 176;
  localparam int unsigned OUT_USER_W      = 2;

  typedef logic [PAYLOAD_DEPTH-1:0][7:0] payload_t;

  // Frame summary handed from the front end to the result stage.
  typedef struct packed {
    logic [15:0]        crc;
    logic [15:0]        tail;
    logic [COUNT_W-1:0] count;
    payload_t           payload;
  } frame_t;

  // Reflected CRC-16, one byte: eight shift/xor steps on 16 bits.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[sv/emrd_front.sv]
// ---------------------------------------------------------------------------
// emrd_front
// Byte intake: running CRC, byte count, two-byte tail and payload capture.
// ---------------------------------------------------------------------------
module emrd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            in_last,
  input  logic            q_full,
  output logic            push,
  output emrd_pkg::frame_t push_item
);

  logic [15:0]                   crc_r, crc_nxt, crc_step;
  logic [15:0]                   tail_r, tail_nxt, tail_step;
  logic [emrd_pkg::COUNT_W-1:0]  pos_r, pos_nxt, cnt_step;
  emrd_pkg::payload_t            payload_r, payload_nxt;
  logic [emrd_pkg::COUNT_W-1:0]  wr_idx;
  logic                          store_en;
  logic                          accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    crc_step  = (pos_r >= 5'd2) ? emrd_pkg::crc16_byte(crc_r, tail_r[15:8]) : crc_r;
    tail_step = {tail_r[7:0], in_byte};
    cnt_step  = (pos_r == emrd_pkg::COUNT_MAX) ? emrd_pkg::COUNT_MAX : pos_r + 5'd1;
    store_en  = (pos_r >= emrd_pkg::COUNT_W'(emrd_pkg::PAYLOAD_FIRST)) &&
                (pos_r <  emrd_pkg::COUNT_W'(emrd_pkg::PAYLOAD_END));
    wr_idx    = pos_r - emrd_pkg::COUNT_W'(emrd_pkg::PAYLOAD_FIRST);
    payload_nxt = payload_r;
    if (store_en) begin
      payload_nxt[wr_idx] = in_byte;
    end
    // restart the frame state after the final byte
    if (accept && in_last) begin
      crc_nxt  = emrd_pkg::CRC_INIT;
      tail_nxt = '0;
      pos_nxt  = '0;
    end else if (accept) begin
      crc_nxt  = crc_step;
      tail_nxt = tail_step;
      pos_nxt  = cnt_step;
    end else begin
      crc_nxt  = crc_r;
      tail_nxt = tail_r;
      pos_nxt  = pos_r;
    end
  end

  assign push              = accept && in_last;
  assign push_item.crc     = crc_step;
  assign push_item.tail    = tail_step;
  assign push_item.count   = cnt_step;
  assign push_item.payload = payload_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= emrd_pkg::CRC_INIT;
      tail_r <= '0;
      pos_r  <= '0;
    end else begin
      crc_r  <= crc_nxt;
      tail_r <= tail_nxt;
      pos_r  <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      payload_r <= payload_nxt;
    end
  end

`include "energy_meter_response_decoder_assert.svh"
  `EMRD_ASSERT_NEXT(a_frame_restart, accept && in_last, pos_r == '0 && crc_r == emrd_pkg::CRC_INIT, "frame state not restored")
  `EMRD_ASSERT(a_push_room, !push || !q_full, "frame pushed into a full queue")

endmodule

[sv/emrd_fifo.sv]
// ---------------------------------------------------------------------------
// emrd_fifo
// Short frame queue between the byte intake and the result stage.
// ---------------------------------------------------------------------------
module emrd_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  emrd_pkg::frame_t push_item,
  input  logic             pop,
  output emrd_pkg::frame_t head,
  output logic             full,
  output logic             empty
);

  emrd_pkg::frame_t                mem_r [emrd_pkg::QDEPTH];
  logic [emrd_pkg::QPTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [emrd_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;

  assign full  = (cnt_r == emrd_pkg::QCNT_W'(emrd_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

`include "energy_meter_response_decoder_assert.svh"
  `EMRD_ASSERT(a_no_underflow, !pop || !empty, "pop from empty queue")
  `EMRD_ASSERT(a_cnt_bound, cnt_r <= emrd_pkg::QCNT_W'(emrd_pkg::QDEPTH), "queue count overrun")

endmodule

[sv/emrd_back.sv]
// ---------------------------------------------------------------------------
// emrd_back
// Result stage: CRC and length verdicts, field extraction, output register.
// ---------------------------------------------------------------------------
module emrd_back #(
  parameter int unsigned FRAME_BYTES = emrd_pkg::FRAME_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  emrd_pkg::frame_t                   head,
  input  logic                               empty,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [emrd_pkg::OUT_DATA_W-1:0]    out_data,
  output logic [emrd_pkg::OUT_USER_W-1:0]    out_user
);

  logic                            valid_r;
  logic [emrd_pkg::OUT_DATA_W-1:0] data_r, data_nxt;
  logic [emrd_pkg::OUT_USER_W-1:0] user_r, user_nxt;
  logic [15:0]                     recv;
  logic                            crc_ok, frame_ok, full;
  emrd_pkg::payload_t              p;

  assign pop = !empty && (!valid_r || out_ready);

  always_comb begin
    p        = head.payload;
    recv     = {head.tail[7:0], head.tail[15:8]};
    crc_ok   = (head.count > 5'd2) && (recv == head.crc);
    frame_ok = crc_ok && (head.count == emrd_pkg::COUNT_W'(FRAME_BYTES));
    full     = head.count >= emrd_pkg::COUNT_W'(emrd_pkg::PAYLOAD_END);
    user_nxt = {crc_ok, frame_ok};
    data_nxt = '0;
    data_nxt[4:0] = head.count;
    // zero the measurements of a short frame
    if (full) begin
      data_nxt[20:5]    = {p[0], p[1]};
      data_nxt[36:21]   = {p[2], p[3]};
      data_nxt[52:37]   = {p[4], p[5]};
      data_nxt[60:53]   = p[6];
      data_nxt[84:61]   = {p[7], p[8], p[9]};
      data_nxt[108:85]  = {p[10], p[11], p[12]};
      data_nxt[140:109] = {p[13], p[14], p[15], p[16]};
      data_nxt[172:141] = {p[17], p[18], p[19], p[20]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data_r <= data_nxt;
      user_r <= user_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;
  assign out_user  = user_r;

`include "energy_meter_response_decoder_assert.svh"
  `EMRD_ASSERT(a_frame_needs_crc, !valid_r || !user_r[0] || user_r[1], "frame_ok without crc_ok")
  `EMRD_ASSERT(a_crc_needs_len, !valid_r || !user_r[1] || (data_r[4:0] > 5'd2), "crc_ok on a frame of two bytes or fewer")

endmodule

[sv/energy_meter_response_decoder.sv]
// ---------------------------------------------------------------------------
// energy_meter_response_decoder
// Modbus RTU measurement reply decoder with CRC-16 and length check.
// ---------------------------------------------------------------------------
// Feed one reply byte per transaction on the in_ side, with in_tlast on the
// final byte. The block takes one byte every clock cycle while in_tready is
// high: the CRC-16 update of a byte is xor logic in the intake, so the intake
// never waits on itself. Every frame gives exactly one result transaction; its
// summary passes through the two-entry frame queue, then the output register.
// in_tready drops only when two finished frames sit in the queue (they pile
// up while out_tready low holds the output register); bytes of the next
// frame keep flowing while a result waits. The CRC covers every byte but the
// trailing two, which must hold the CRC low byte first. Measurement fields
// read as zero when the frame is shorter than 24 bytes; byte_count saturates
// at 31.
// ---------------------------------------------------------------------------
module energy_meter_response_decoder #(
  parameter int unsigned FRAME_BYTES = emrd_pkg::FRAME_BYTES_DEF  // 26 to 31
) (
  input  logic         clk,
  input  logic         rst_n,
  // byte intake
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] rx_byte
  input  logic         in_tlast,   // last_byte
  // frame results
  output logic         out_tvalid,
  input  logic         out_tready,
  // [4:0] byte_count, [20:5] voltage_raw, [36:21] current_raw,
  // [52:37] frequency_raw, [60:53] power_factor_raw (signed),
  // [84:61] active_power_raw (signed), [108:85] apparent_power_raw,
  // [140:109] energy_forward_raw, [172:141] energy_reverse_raw, [175:173] zero
  output logic [175:0] out_tdata,
  output logic [1:0]   out_tuser   // [0] frame_ok, [1] crc_ok
);

  logic             push, pop, q_full, q_empty;
  emrd_pkg::frame_t push_item, head;

  // intake: count, CRC, tail and payload capture
  emrd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  // decouple intake from a stalled result channel
  emrd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // verdicts, field unpacking and the output register
  emrd_back #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_user  (out_tuser)
  );

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Testbench for energy_meter_response_decoder
// Drives meter reply frames, one byte per transaction, into the decoder and
// checks every reading it returns against a local model of the frame CRC,
// the byte count and the measurement fields. Directed frames come first,
// then a long random run. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAME_LEN  = emrd_pkg::FRAME_BYTES_DEF;
  localparam int unsigned LONG_HOLD  = 400;   // cycles the reading side holds off once
  localparam int unsigned RAND_BYTES = 555;   // random bytes to offer, at the least
  localparam int unsigned RAND_FRAMES = 20;   // random frames to offer, at the least
  localparam int unsigned SETTLE     = 10;    // cycles to watch for strays at the end

  // One byte waiting to be offered; drain holds it back until no reading is due.
  typedef struct {
    logic [7:0] value;
    logic       last;
    logic       drain;
  } stream_item_t;

  // One decoded reading, as the result channel carries it.
  typedef struct {
    logic               frame_ok;
    logic               crc_ok;
    logic [4:0]         count;
    logic [15:0]        voltage;
    logic [15:0]        current;
    logic [15:0]        frequency;
    logic signed [7:0]  power_factor;
    logic signed [23:0] active_power;
    logic [23:0]        apparent_power;
    logic [31:0]        energy_fwd;
    logic [31:0]        energy_rev;
    logic [2:0]         padding;
  } reading_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = '0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [175:0] out_tdata;
  logic [1:0]   out_tuser;

  stream_item_t byte_stream[$];
  reading_t     awaited_readings[$];
  logic [7:0]   frame_buf[$];

  // Local copy of the decoder's frame state
  logic [15:0]  crc_run = emrd_pkg::CRC_INIT;
  logic [4:0]   byte_tally = '0;
  logic [15:0]  trailing_pair = '0;
  logic [7:0]   payload_bytes[emrd_pkg::PAYLOAD_DEPTH];

  bit  failed = 1'b0;
  bit  in_taken = 1'b0;
  bit  hold_done = 1'b0;
  int  frames_queued = 0;
  int  readings_seen = 0;
  int  hold_at = 0;
  int  hold_left = 0;
  int  in_gap = 0;
  int  in_steady = 0;
  int  out_stall = 0;
  int  out_steady = 0;

  energy_meter_response_decoder #(
    .FRAME_BYTES(FRAME_LEN)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Reflected CRC-16 over one byte, bit by bit
  function automatic logic [15:0] meter_crc(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) begin
      if (c[0]) begin
        c = (c >> 1) ^ emrd_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Gap length: mostly none, some short, a few long; now and then a stretch
  // of back-to-back cycles with no gap at all.
  function automatic int pick_gap(inout int steady);
    int r;
    if (steady > 0) begin
      steady--;
      return 0;
    end
    r = $urandom_range(0, 999);
    if (r < 5) begin
      steady = $urandom_range(40, 160);
      return 0;
    end
    if (r < 600) return 0;
    if (r < 900) return $urandom_range(1, 3);
    if (r < 985) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Advance the frame model by one accepted byte; on the final byte, queue
  // the reading it must give and restore the frame state.
  task automatic absorb_reply_byte(input logic [7:0] b, input logic last);
    logic [4:0]  pos;
    logic [4:0]  n;
    logic [15:0] received;
    reading_t    r;
    pos = byte_tally;
    if (pos >= 2) crc_run = meter_crc(crc_run, trailing_pair[15:8]);
    trailing_pair = {trailing_pair[7:0], b};
    if (pos >= emrd_pkg::PAYLOAD_FIRST && pos < emrd_pkg::PAYLOAD_END)
      payload_bytes[pos - emrd_pkg::PAYLOAD_FIRST] = b;
    n = (pos < emrd_pkg::COUNT_MAX) ? pos + 5'd1 : emrd_pkg::COUNT_MAX;
    byte_tally = n;
    if (last) begin
      // Trailer arrives low byte first
      received = {trailing_pair[7:0], trailing_pair[15:8]};
      r = '{default: '0};
      r.crc_ok   = (n > 2) && (received == crc_run);
      r.frame_ok = r.crc_ok && (n == FRAME_LEN);
      r.count    = n;
      // Measurement fields only once the whole payload was seen in this frame
      if (n >= emrd_pkg::PAYLOAD_END) begin
        r.voltage        = {payload_bytes[0], payload_bytes[1]};
        r.current        = {payload_bytes[2], payload_bytes[3]};
        r.frequency      = {payload_bytes[4], payload_bytes[5]};
        r.power_factor   = payload_bytes[6];
        r.active_power   = {payload_bytes[7], payload_bytes[8], payload_bytes[9]};
        r.apparent_power = {payload_bytes[10], payload_bytes[11], payload_bytes[12]};
        r.energy_fwd     = {payload_bytes[13], payload_bytes[14], payload_bytes[15],
                            payload_bytes[16]};
        r.energy_rev     = {payload_bytes[17], payload_bytes[18], payload_bytes[19],
                            payload_bytes[20]};
      end
      awaited_readings.push_back(r);
      crc_run       = emrd_pkg::CRC_INIT;
      byte_tally    = '0;
      trailing_pair = '0;
    end
  endtask

  // Fill the frame buffer with random bytes or a fixed byte
  task automatic load_frame(input int len, input bit random_fill, input logic [7:0] fill);
    frame_buf.delete();
    for (int k = 0; k < len; k++)
      frame_buf.push_back(random_fill ? 8'($urandom_range(0, 255)) : fill);
  endtask

  // Seal the buffered frame with its CRC if asked, then queue its bytes
  task automatic enqueue_frame(input bit seal, input bit drain);
    logic [15:0]  crc;
    stream_item_t item;
    int           n;
    n = frame_buf.size();
    if (seal && n >= 3) begin
      crc = emrd_pkg::CRC_INIT;
      for (int k = 0; k < n - 2; k++) crc = meter_crc(crc, frame_buf[k]);
      frame_buf[n-2] = crc[7:0];
      frame_buf[n-1] = crc[15:8];
    end
    for (int k = 0; k < n; k++) begin
      item.value = frame_buf[k];
      item.last  = (k == n - 1);
      item.drain = drain && (k == 0);
      byte_stream.push_back(item);
    end
    frames_queued++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: reading %0d %s mismatch, expected %h, actual %h",
               $realtime, readings_seen, name, want, got);
      failed = 1'b1;
    end
  endtask

  // Byte driver: change inputs on the falling edge. Hold an offered byte
  // until it is taken, then idle for a random gap before the next one.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (in_taken) begin
        in_taken = 1'b0;
        in_gap   = pick_gap(in_steady);
      end
      if (in_gap > 0) begin
        in_tvalid <= 1'b0;
        in_gap--;
      end else if (byte_stream.size() != 0 &&
                   (!byte_stream[0].drain || awaited_readings.size() == 0)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= byte_stream[0].value;
        in_tlast  <= byte_stream[0].last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Reading side: random stalls, plus one long hold-off once the directed
  // readings are in, so that the frame queue fills and the intake backs up.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (!hold_done && readings_seen >= hold_at) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      out_tready <= 1'b0;
    end else if (out_stall > 0) begin
      out_tready <= 1'b0;
      out_stall--;
    end else begin
      out_stall = pick_gap(out_steady);
      out_tready <= (out_stall == 0);
    end
  end

  // Monitor: sample both handshakes on the rising edge. Feed each accepted
  // byte to the model, and check each reading against the oldest one due.
  always @(posedge clk) begin
    reading_t got;
    reading_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        absorb_reply_byte(in_tdata, in_tlast);
        void'(byte_stream.pop_front());
        in_taken = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        got.frame_ok       = out_tuser[0];
        got.crc_ok         = out_tuser[1];
        got.count          = out_tdata[4:0];
        got.voltage        = out_tdata[20:5];
        got.current        = out_tdata[36:21];
        got.frequency      = out_tdata[52:37];
        got.power_factor   = out_tdata[60:53];
        got.active_power   = out_tdata[84:61];
        got.apparent_power = out_tdata[108:85];
        got.energy_fwd     = out_tdata[140:109];
        got.energy_rev     = out_tdata[172:141];
        got.padding        = out_tdata[175:173];
        if (awaited_readings.size() == 0) begin
          $display("%0t ns: unexpected reading, expected none, actual tuser %h tdata %h",
                   $realtime, out_tuser, out_tdata);
          failed = 1'b1;
        end else begin
          want = awaited_readings.pop_front();
          compare_field("frame_ok", want.frame_ok, got.frame_ok);
          compare_field("crc_ok", want.crc_ok, got.crc_ok);
          compare_field("byte_count", want.count, got.count);
          compare_field("voltage_raw", want.voltage, got.voltage);
          compare_field("current_raw", want.current, got.current);
          compare_field("frequency_raw", want.frequency, got.frequency);
          compare_field("power_factor_raw", want.power_factor, got.power_factor);
          compare_field("active_power_raw", want.active_power, got.active_power);
          compare_field("apparent_power_raw", want.apparent_power, got.apparent_power);
          compare_field("energy_forward_raw", want.energy_fwd, got.energy_fwd);
          compare_field("energy_reverse_raw", want.energy_rev, got.energy_rev);
          compare_field("tdata padding", want.padding, got.padding);
        end
        readings_seen++;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int rand_bytes;
    int rand_frames;
    int len;
    int pick;
    int spot;

    // Directed: extremes of every field, good and bad CRC, every length class
    load_frame(FRAME_LEN, 1'b0, 8'h00);
    enqueue_frame(1'b1, 1'b0);
    load_frame(FRAME_LEN, 1'b0, 8'hFF);
    enqueue_frame(1'b1, 1'b0);
    // most negative power factor and active power
    load_frame(FRAME_LEN, 1'b1, 8'h00);
    frame_buf[9]  = 8'h80;
    frame_buf[10] = 8'h80;
    frame_buf[11] = 8'h00;
    frame_buf[12] = 8'h00;
    enqueue_frame(1'b1, 1'b0);
    // most positive power factor and active power
    load_frame(FRAME_LEN, 1'b1, 8'h00);
    frame_buf[9]  = 8'h7F;
    frame_buf[10] = 8'h7F;
    frame_buf[11] = 8'hFF;
    frame_buf[12] = 8'hFF;
    enqueue_frame(1'b1, 1'b0);
    // right length, trailer broken
    load_frame(FRAME_LEN, 1'b1, 8'h00);
    enqueue_frame(1'b1, 1'b0);
    byte_stream[byte_stream.size() - 1].value ^= 8'h01;
    // one and two byte frames can never pass the CRC check
    load_frame(1, 1'b1, 8'h00);
    enqueue_frame(1'b0, 1'b0);
    load_frame(2, 1'b0, 8'hFF);
    enqueue_frame(1'b0, 1'b0);
    // shortest frame with a good CRC, then payload just short and just full
    load_frame(3, 1'b1, 8'h00);
    enqueue_frame(1'b1, 1'b0);
    load_frame(emrd_pkg::PAYLOAD_END - 1, 1'b1, 8'h00);
    enqueue_frame(1'b1, 1'b0);
    load_frame(emrd_pkg::PAYLOAD_END, 1'b1, 8'h00);
    enqueue_frame(1'b1, 1'b0);
    // good CRC at the wrong lengths; past 31 bytes the count saturates
    load_frame(FRAME_LEN - 1, 1'b1, 8'h00);
    enqueue_frame(1'b1, 1'b0);
    load_frame(31, 1'b1, 8'h00);
    enqueue_frame(1'b1, 1'b0);
    load_frame(40, 1'b1, 8'h00);
    enqueue_frame(1'b1, 1'b0);

    // Start the long hold-off once the directed readings are in, and keep a
    // burst of one-byte frames coming so that the decoder fills and stalls.
    hold_at = frames_queued;
    repeat (10) begin
      load_frame(1, 1'b1, 8'h00);
      enqueue_frame(1'b0, 1'b0);
    end

    // Random: mostly sealed frames of the right length with random content,
    // the rest corrupted, odd-length or unsealed. Pause for a drain at the
    // start and now and then after.
    rand_bytes  = 0;
    rand_frames = 0;
    while (rand_bytes < RAND_BYTES || rand_frames < RAND_FRAMES) begin
      pick = $urandom_range(0, 99);
      len  = (pick < 80) ? FRAME_LEN : $urandom_range(1, 40);
      load_frame(len, 1'b1, 8'h00);
      enqueue_frame(pick < 90, rand_frames == 0 || $urandom_range(0, 39) == 0);
      if (pick >= 70 && pick < 80) begin
        spot = byte_stream.size() - $urandom_range(1, len);
        byte_stream[spot].value ^= 8'(1 << $urandom_range(0, 7));
      end
      rand_bytes += len;
      rand_frames++;
    end

    rst_n = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Wait for every byte to go in and every reading to come out
    while (byte_stream.size() != 0 || awaited_readings.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (!failed && awaited_readings.size() == 0) begin
      $display("energy_meter_response_decoder test passed");
    end else begin
      $display("energy_meter_response_decoder test failed");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest legal run
  initial begin
    #8_000_000;
    $display("energy_meter_response_decoder test failed");
    $finish;
  end

endmodule
